// ===== design/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the edge surface crossing block
// Holds the bisection depth, the configuration bundle and the per-edge record
// that moves down the chain of bisection cells.
// ----------------------------------------------------------------------------
package esc_pkg;

    // Number of bisection steps, one cell each.
    localparam int FRAC_STEPS = 20;
    // Width to which vertex numbers are masked.
    localparam int INDEX_BITS = 20;
    // Output widths fixed by the result format.
    localparam int IDX_W  = 20;
    localparam int FRAC_W = 20;
    // Register stages in one inside test.
    localparam int INS_LAT  = 4;
    // Register stages in one bisection cell: product, point, then the inside test.
    localparam int CELL_LAT = INS_LAT + 2;

    // Mask applied to incoming vertex numbers.
    localparam logic [63:0] IDX_MASK_W = (64'd1 << INDEX_BITS) - 64'd1;
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_MASK_W[IDX_W-1:0];

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_SHAPE_MODE = 3'd0;
    localparam logic [2:0] REG_CENTER_X   = 3'd1;
    localparam logic [2:0] REG_CENTER_Y   = 3'd2;
    localparam logic [2:0] REG_CENTER_Z   = 3'd3;
    localparam logic [2:0] REG_INV_HALF_X = 3'd4;
    localparam logic [2:0] REG_INV_HALF_Y = 3'd5;
    localparam logic [2:0] REG_INV_HALF_Z = 3'd6;

    // Solid description; the user must hold it static while items are in flight, the block does not enforce this.
    typedef struct packed {
        logic             shape_mode;
        logic [2:0][31:0] center;
        logic [2:0][31:0] inv_half;
    } cfg_t;

    // One edge as it travels through the chain.
    typedef struct packed {
        logic [2:0][31:0]      a;
        logic [2:0][31:0]      dmag;
        logic [2:0]            dneg;
        logic                  ina;
        logic                  cr;
        logic [FRAC_STEPS-1:0] lo;
        logic [IDX_W-1:0]      lo_i;
        logic [IDX_W-1:0]      hi_i;
    } item_t;

endpackage

// ===== design/esc_inside.sv =====
// ----------------------------------------------------------------------------
// esc_inside: pipelined point-in-solid test
// Normalizes the offset of a point from the solid center on each axis and
// applies the box or ellipsoid rule. Four register stages, no stall logic of
// its own beyond the shared advance enable.
// ----------------------------------------------------------------------------
module esc_inside (
    input  logic                     clk,
    input  logic                     adv,
    input  esc_pkg::cfg_t            cfg,
    input  logic [2:0][31:0]         pt,
    output logic                     hit
);
    import esc_pkg::*;

    logic [2:0][31:0] mag_reg;
    logic [2:0][63:0] norm_reg;
    logic [2:0][47:0] sq_reg;
    logic             ovf_reg;
    logic             inside_reg;
    logic [2:0][31:0] mag_next;
    logic [2:0][47:0] sq_next;
    logic [2:0][23:0] q;
    logic [49:0]      sum;
    logic [32:0]      diff;
    logic             ovf_next;

    // Absolute offset from the center, and the squares of the Q0.24 offsets.
    always_comb
    begin
        ovf_next = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            diff = {pt[k][31], pt[k]} - {cfg.center[k][31], cfg.center[k]};
            mag_next[k] = diff[32] ? 32'(-diff) : diff[31:0];
            q[k] = norm_reg[k][31:8];
            sq_next[k] = 48'(q[k]) * 48'(q[k]);
            ovf_next = ovf_next | (norm_reg[k][63:32] != 32'd0);
        end
        sum = 50'(sq_reg[0]) + 50'(sq_reg[1]) + 50'(sq_reg[2]);
    end

    // Stages: magnitude, normalized offset, squares, decision.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg <= mag_next;
            for (int k = 0; k < 3; k++)
            begin
                norm_reg[k] <= 64'(mag_reg[k]) * 64'(cfg.inv_half[k]);
            end
            sq_reg     <= sq_next;
            ovf_reg    <= ovf_next;
            inside_reg <= !ovf_reg && (cfg.shape_mode || (sum[49:48] == 2'd0));
        end
    end

    assign hit = inside_reg;

endmodule

// ===== design/esc_cell.sv =====
// ----------------------------------------------------------------------------
// esc_cell: one bisection step
// Places the midpoint on the edge, tests it against the solid and narrows the
// bracket. The edge record moves one stage per advance and leaves the cell
// with its left bracket updated.
// ----------------------------------------------------------------------------
module esc_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic [esc_pkg::FRAC_STEPS-1:0]  bit_mask,
    input  esc_pkg::cfg_t                   cfg,
    input  logic                            in_valid,
    input  esc_pkg::item_t                  in_item,
    output logic                            out_valid,
    output esc_pkg::item_t                  out_item
);
    import esc_pkg::*;

    item_t                      c1_item_reg;
    item_t                      c2_item_reg;
    item_t                      dl_item_reg [INS_LAT];
    logic                       c1_valid_reg;
    logic                       c2_valid_reg;
    logic [INS_LAT-1:0]         dl_valid_reg;
    logic [2:0][FRAC_STEPS+31:0] prod_reg;
    logic [2:0][31:0]           pt_reg;
    logic [2:0][31:0]           pt_next;
    logic [2:0][31:0]           step_len;
    logic [FRAC_STEPS-1:0]      mid_in;
    logic                       pt_inside;
    item_t                      last;

    assign mid_in = in_item.lo | bit_mask;

    // Point on the edge at the midpoint of the bracket.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            step_len[k] = prod_reg[k][FRAC_STEPS+31:FRAC_STEPS];
            pt_next[k] = c1_item_reg.dneg[k] ?
                         32'({c1_item_reg.a[k][31], c1_item_reg.a[k]} - {1'b0, step_len[k]}) :
                         32'({c1_item_reg.a[k][31], c1_item_reg.a[k]} + {1'b0, step_len[k]});
        end
    end

    // Valid bits of the cell stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
            dl_valid_reg <= '0;
        end
        else if (adv)
        begin
            c1_valid_reg <= in_valid;
            c2_valid_reg <= c1_valid_reg;
            dl_valid_reg <= {dl_valid_reg[INS_LAT-2:0], c2_valid_reg};
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_item_reg <= in_item;
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= (FRAC_STEPS+32)'(in_item.dmag[k]) *
                               (FRAC_STEPS+32)'(mid_in);
            end
            c2_item_reg <= c1_item_reg;
            pt_reg      <= pt_next;
            dl_item_reg[0] <= c2_item_reg;
            for (int i = 1; i < INS_LAT; i++)
            begin
                dl_item_reg[i] <= dl_item_reg[i-1];
            end
        end
    end

    esc_inside u_inside (
        .clk    (clk),
        .adv    (adv),
        .cfg    (cfg),
        .pt     (pt_reg),
        .hit    (pt_inside)
    );

    // Keep the left bracket where the side changed, else move it to the midpoint.
    always_comb
    begin
        last = dl_item_reg[INS_LAT-1];
        if (pt_inside == last.ina)
        begin
            last.lo = last.lo | bit_mask;
        end
        out_item = last;
    end

    assign out_valid = dl_valid_reg[INS_LAT-1];

endmodule

// ===== design/edge_surface_crossing_bisect.sv =====
// ----------------------------------------------------------------------------
// edge_surface_crossing_bisect: edge crossing search against an implicit solid
// Tests both ends of a mesh edge against an ellipsoid or an axis box and
// bisects the crossing through a chain of step cells.
// ----------------------------------------------------------------------------
// Usage:
// Edges enter on the slave stream (s_tvalid, s_tready, s_tdata); each
// transaction carries both endpoints and their vertex numbers. Results leave
// on the master stream, one transaction per edge, in input order.
// The solid must be set through the APB port only while no edge is in flight;
// the block itself does not enforce this. The path runs through one input
// register, the endpoint tests, the chain of bisection cells and the output
// register. One edge is taken every cycle unless the receiver stalls the chain.
// Every stage moves on a single advance enable; when the receiver stalls with
// a result waiting, the whole chain holds and s_tready drops, and it resumes
// without loss when m_tready returns.
// Reset clears all valid bits and loads the register defaults: ellipsoid,
// center at the origin, unit half-sizes.
// ----------------------------------------------------------------------------
module edge_surface_crossing_bisect (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, start_index, end_index
    input  logic [231:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // crosses, low_index, high_index, fraction, zero fill
    output logic [63:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import esc_pkg::*;

    logic             shape_mode_reg;
    logic [2:0][31:0] center_reg;
    logic [2:0][31:0] inv_half_reg;
    cfg_t             cfg;
    logic             adv;
    logic [2:0]       reg_idx;

    logic             f0_valid_reg;
    logic [2:0][31:0] f0_a_reg;
    logic [2:0][31:0] f0_b_reg;
    logic [IDX_W-1:0] f0_lo_i_reg;
    logic [IDX_W-1:0] f0_hi_i_reg;
    logic [2:0][31:0] in_s;
    logic [2:0][31:0] in_e;
    logic [IDX_W-1:0] in_si;
    logic [IDX_W-1:0] in_ei;

    item_t              fr_item;
    item_t              fr_item_reg [INS_LAT];
    logic [INS_LAT-1:0] fr_valid_reg;
    logic               ins_a;
    logic               ins_b;
    logic [32:0]        dd;

    item_t                 cell_item  [FRAC_STEPS+1];
    logic [FRAC_STEPS:0]   cell_valid;

    logic                  out_valid_reg;
    logic [63:0]           out_data_reg;
    logic [FRAC_STEPS+19:0] frac_wide;
    logic [FRAC_W-1:0]     frac;

    // Configuration registers.
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_mode_reg <= 1'b0;
            center_reg     <= '0;
            inv_half_reg   <= {3{32'd65536}};
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                REG_SHAPE_MODE: shape_mode_reg  <= pwdata[0];
                REG_CENTER_X:   center_reg[0]   <= pwdata;
                REG_CENTER_Y:   center_reg[1]   <= pwdata;
                REG_CENTER_Z:   center_reg[2]   <= pwdata;
                REG_INV_HALF_X: inv_half_reg[0] <= pwdata;
                REG_INV_HALF_Y: inv_half_reg[1] <= pwdata;
                REG_INV_HALF_Z: inv_half_reg[2] <= pwdata;
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_idx)
            REG_SHAPE_MODE: prdata = {31'd0, shape_mode_reg};
            REG_CENTER_X:   prdata = center_reg[0];
            REG_CENTER_Y:   prdata = center_reg[1];
            REG_CENTER_Z:   prdata = center_reg[2];
            REG_INV_HALF_X: prdata = inv_half_reg[0];
            REG_INV_HALF_Y: prdata = inv_half_reg[1];
            REG_INV_HALF_Z: prdata = inv_half_reg[2];
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.shape_mode = shape_mode_reg;
    assign cfg.center     = center_reg;
    assign cfg.inv_half   = inv_half_reg;

    // The whole chain moves whenever the output register can take a result.
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // Unpack the incoming transaction.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            in_s[k] = s_tdata[32*k +: 32];
            in_e[k] = s_tdata[96 + 32*k +: 32];
        end
        in_si = s_tdata[192 +: IDX_W] & IDX_MASK;
        in_ei = s_tdata[212 +: IDX_W] & IDX_MASK;
    end

    // Input stage: order the ends by vertex number.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (in_si < in_ei)
            begin
                f0_a_reg    <= in_s;
                f0_b_reg    <= in_e;
                f0_lo_i_reg <= in_si;
                f0_hi_i_reg <= in_ei;
            end
            else
            begin
                f0_a_reg    <= in_e;
                f0_b_reg    <= in_s;
                f0_lo_i_reg <= in_ei;
                f0_hi_i_reg <= in_si;
            end
        end
    end

    // Endpoint tests.
    esc_inside u_ins_a (
        .clk    (clk),
        .adv    (adv),
        .cfg    (cfg),
        .pt     (f0_a_reg),
        .hit    (ins_a)
    );

    esc_inside u_ins_b (
        .clk    (clk),
        .adv    (adv),
        .cfg    (cfg),
        .pt     (f0_b_reg),
        .hit    (ins_b)
    );

    // Edge record with direction and length per axis.
    always_comb
    begin
        fr_item = '0;
        fr_item.a    = f0_a_reg;
        fr_item.lo_i = f0_lo_i_reg;
        fr_item.hi_i = f0_hi_i_reg;
        for (int k = 0; k < 3; k++)
        begin
            dd = {f0_b_reg[k][31], f0_b_reg[k]} - {f0_a_reg[k][31], f0_a_reg[k]};
            fr_item.dneg[k] = dd[32];
            fr_item.dmag[k] = dd[32] ? 32'(-dd) : dd[31:0];
        end
    end

    // Hold the record while the endpoint tests run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= '0;
        end
        else if (adv)
        begin
            fr_valid_reg <= {fr_valid_reg[INS_LAT-2:0], f0_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fr_item_reg[0] <= fr_item;
            for (int i = 1; i < INS_LAT; i++)
            begin
                fr_item_reg[i] <= fr_item_reg[i-1];
            end
        end
    end

    always_comb
    begin
        cell_item[0]     = fr_item_reg[INS_LAT-1];
        cell_item[0].ina = ins_a;
        cell_item[0].cr  = ins_a ^ ins_b;
        cell_item[0].lo  = '0;
    end
    assign cell_valid[0] = fr_valid_reg[INS_LAT-1];

    // Chain of bisection cells, the most significant bracket bit first.
    for (genvar g = 0; g < FRAC_STEPS; g++)
    begin : g_cell
        localparam logic [FRAC_STEPS-1:0] STEP_BIT =
            FRAC_STEPS'(1) << (FRAC_STEPS - 1 - g);

        esc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .bit_mask  (STEP_BIT),
            .cfg       (cfg),
            .in_valid  (cell_valid[g]),
            .in_item   (cell_item[g]),
            .out_valid (cell_valid[g+1]),
            .out_item  (cell_item[g+1])
        );
    end

    // Rescale the bracket to twenty fraction bits.
    assign frac_wide = {cell_item[FRAC_STEPS].lo, 20'd0} >> FRAC_STEPS;
    assign frac      = cell_item[FRAC_STEPS].cr ? frac_wide[FRAC_W-1:0] : '0;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= cell_valid[FRAC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {3'd0, frac, cell_item[FRAC_STEPS].hi_i,
                             cell_item[FRAC_STEPS].lo_i, cell_item[FRAC_STEPS].cr};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A result without a crossing carries no fraction.
    a_frac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[60:41] == 20'd0)
        else $error("fraction set on a transaction without crossing");

    // Vertex numbers leave in order.
    a_idx_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[20:1] <= m_tdata[40:21])
        else $error("low_index above high_index");

    // The chain holds while the receiver stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(cell_valid) && $stable(fr_valid_reg))
        else $error("pipeline moved during a stall");

endmodule
